[hw/rtl/sil_pkg.sv]
// Shared types and constants for the sorted insert list.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package sil_pkg;

    // default geometry
    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 31;

    // request kinds
    typedef enum logic [1:0] {
        FUNC_ADD      = 2'd0,
        FUNC_GET      = 2'd1,
        FUNC_SET      = 2'd2,
        FUNC_CONTAINS = 2'd3
    } func_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    // request sequencer states
    typedef enum logic [1:0] {
        S_IDLE    = 2'd0,
        S_COMPARE = 2'd1,
        S_APPLY   = 2'd2
    } state_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic capture;     // register compare flags
        logic ins_sorted;  // ordered insert with shift
        logic append;      // write at the tail position
        logic set;         // overwrite the selected position
    } cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/sil_ifs.sv]
// Handshake channels of the sorted insert list: request, response, config.
// Depends on sil_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

interface sil_req_if #(
    parameter int VALUE_BITS = sil_pkg::VALUE_BITS,
    parameter int INDEX_BITS = $clog2(sil_pkg::CAPACITY)
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            func;
    logic [VALUE_BITS-1:0] value;
    logic [INDEX_BITS-1:0] index;

    modport source (output valid, output func, output value, output index, input ready);
    modport sink   (input valid, input func, input value, input index, output ready);
endinterface

interface sil_rsp_if #(
    parameter int VALUE_BITS = sil_pkg::VALUE_BITS,
    parameter int COUNT_BITS = $clog2(sil_pkg::CAPACITY + 1)
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] read_value;
    logic                  found;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] entry_count;

    modport source (output valid, output read_value, output found, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input read_value, input found, input status,
                    input entry_count, output ready);
endinterface

interface sil_cfg_if;
    logic valid;
    logic ready;
    logic keep_sorted;

    modport source (output valid, output keep_sorted, input ready);
    modport sink   (input valid, input keep_sorted, output ready);
endinterface

`default_nettype wire

[hw/rtl/sil_cell.sv]
// One list position: holds an entry, compares it against the request and
// shifts from its left neighbour on ordered insert. Depends on sil_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sil_cell #(
    parameter int VALUE_BITS = sil_pkg::VALUE_BITS,
    parameter int INDEX_BITS = 6,
    parameter int COUNT_BITS = 7,
    parameter int POS        = 0
) (
    input  wire logic                  clk,
    input  wire sil_pkg::cell_ctl_t    ctl,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic [INDEX_BITS-1:0] index,
    input  wire logic [COUNT_BITS-1:0] count,
    input  wire logic [VALUE_BITS-1:0] left_entry,
    input  wire logic                  shift_in,
    input  wire logic [VALUE_BITS-1:0] rd_in,
    input  wire logic                  found_in,
    output logic      [VALUE_BITS-1:0] entry,
    output logic                       shift_out,
    output logic      [VALUE_BITS-1:0] rd_out,
    output logic                       found_out
);

    localparam logic [COUNT_BITS-1:0] POS_C = COUNT_BITS'(POS);
    localparam logic [INDEX_BITS-1:0] POS_I = INDEX_BITS'(POS);

    logic [VALUE_BITS-1:0] entry_reg;
    logic [VALUE_BITS-1:0] entry_next;
    logic                  ge_reg;
    logic                  eq_reg;
    logic                  sel_reg;
    logic                  tail_reg;
    logic                  occupied;

    assign occupied = (POS_C < count);

    // compare flags, taken once per request
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            ge_reg   <= occupied && (entry_reg >= value);
            eq_reg   <= occupied && (entry_reg == value);
            sel_reg  <= (index == POS_I);
            tail_reg <= (count == POS_C);
        end
    end

    // entry update: shift, insert, append or overwrite
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins_sorted)
        begin
            if (shift_in)
                entry_next = left_entry;
            else if (ge_reg || tail_reg)
                entry_next = value;
        end
        else if (ctl.append && tail_reg)
            entry_next = value;
        else if (ctl.set && sel_reg)
            entry_next = value;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // chained results towards the last cell
    assign entry     = entry_reg;
    assign shift_out = shift_in | ge_reg;
    assign rd_out    = rd_in | (sel_reg ? entry_reg : '0);
    assign found_out = found_in | eq_reg;

endmodule

`default_nettype wire

[hw/rtl/sorted_insert_list.sv]
// Top level of the sorted insert list: request sequencer, count, config
// register and the row of sil_cell positions. Depends on sil_pkg, sil_ifs.
`timescale 1ns / 1ps
`default_nettype none

// A bounded list of up to CAPACITY values held in a row of cells, one entry
// per cell. Requests are add, get, set and contains; every request gives one
// response word. Each request passes through S_IDLE, S_COMPARE and S_APPLY:
// the word is accepted, all cells compare their entry with the request in
// parallel, and once the output register is free the cells shift or write
// and the response is loaded into the output register. A request is taken
// only in S_IDLE, after the update of the one before. A new request is
// accepted while an earlier response still waits; the update of the
// following request waits only if that response has not been taken by then.
// keep_sorted selects an ordered insert (before the first entry that is not
// smaller) or an append; it is written through the config channel, which is
// always ready, and must only change while the block is idle. Entries are
// not cleared at reset; only positions below the entry count are ever read.
module sorted_insert_list #(
    parameter int CAPACITY   = sil_pkg::CAPACITY,
    parameter int VALUE_BITS = sil_pkg::VALUE_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sil_req_if.sink   req,
    sil_rsp_if.source rsp,
    sil_cfg_if.sink   cfg
);

    localparam int INDEX_BITS = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam logic [COUNT_BITS-1:0] CAP_C = COUNT_BITS'(CAPACITY);

    sil_pkg::state_t         state_reg;
    sil_pkg::state_t         state_next;
    sil_pkg::func_t          req_func_reg;
    logic [VALUE_BITS-1:0]   req_value_reg;
    logic [INDEX_BITS-1:0]   req_index_reg;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   count_next;
    logic                    keep_sorted_reg;
    logic                    rsp_valid_reg;
    logic [VALUE_BITS-1:0]   rsp_value_reg;
    logic                    rsp_found_reg;
    sil_pkg::status_t        rsp_status_reg;
    logic [COUNT_BITS-1:0]   rsp_count_reg;

    sil_pkg::cell_ctl_t      ctl;
    sil_pkg::status_t        status;
    logic                    req_fire;
    logic                    out_free;
    logic                    apply;
    logic                    ok;

    logic [VALUE_BITS-1:0]   entry_w [CAPACITY];
    logic [VALUE_BITS-1:0]   rd_c    [CAPACITY+1];
    logic                    shift_c [CAPACITY+1];
    logic                    found_c [CAPACITY+1];

    assign req_fire = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;

    // config register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            keep_sorted_reg <= 1'b0;
        else if (cfg.valid)
            keep_sorted_reg <= cfg.keep_sorted;
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_func_reg  <= sil_pkg::func_t'(req.func);
            req_value_reg <= req.value;
            req_index_reg <= req.index;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sil_pkg::S_IDLE:
                if (req_fire)
                    state_next = sil_pkg::S_COMPARE;
            sil_pkg::S_COMPARE:
                state_next = sil_pkg::S_APPLY;
            sil_pkg::S_APPLY:
                if (out_free)
                    state_next = sil_pkg::S_IDLE;
            default:
                state_next = sil_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sil_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // status of the held request
    always_comb
    begin
        status = sil_pkg::STAT_OK;
        case (req_func_reg)
            sil_pkg::FUNC_ADD:
                if (count_reg == CAP_C)
                    status = sil_pkg::STAT_FULL;
            sil_pkg::FUNC_GET,
            sil_pkg::FUNC_SET:
                if (COUNT_BITS'(req_index_reg) >= count_reg)
                    status = sil_pkg::STAT_RANGE;
            default:
                status = sil_pkg::STAT_OK;
        endcase
    end

    assign ok = (status == sil_pkg::STAT_OK);

    // sequencer outputs
    always_comb
    begin
        req.ready      = 1'b0;
        apply          = 1'b0;
        ctl.capture    = 1'b0;
        ctl.ins_sorted = 1'b0;
        ctl.append     = 1'b0;
        ctl.set        = 1'b0;
        case (state_reg)
            sil_pkg::S_IDLE:
                req.ready = 1'b1;
            sil_pkg::S_COMPARE:
                ctl.capture = 1'b1;
            sil_pkg::S_APPLY:
            begin
                apply          = out_free;
                ctl.ins_sorted = out_free && ok && (req_func_reg == sil_pkg::FUNC_ADD)
                                 && keep_sorted_reg;
                ctl.append     = out_free && ok && (req_func_reg == sil_pkg::FUNC_ADD)
                                 && !keep_sorted_reg;
                ctl.set        = out_free && ok && (req_func_reg == sil_pkg::FUNC_SET);
            end
            default:
                req.ready = 1'b0;
        endcase
    end

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (ok && (req_func_reg == sil_pkg::FUNC_ADD))
            count_next = count_reg + COUNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (apply)
            count_reg <= count_next;
    end

    // cell row
    assign shift_c[0] = 1'b0;
    assign rd_c[0]    = '0;
    assign found_c[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [VALUE_BITS-1:0] left_w;
        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_rest
            assign left_w = entry_w[g-1];
        end

        sil_cell #(
            .VALUE_BITS (VALUE_BITS),
            .INDEX_BITS (INDEX_BITS),
            .COUNT_BITS (COUNT_BITS),
            .POS        (g)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .value      (req_value_reg),
            .index      (req_index_reg),
            .count      (count_reg),
            .left_entry (left_w),
            .shift_in   (shift_c[g]),
            .rd_in      (rd_c[g]),
            .found_in   (found_c[g]),
            .entry      (entry_w[g]),
            .shift_out  (shift_c[g+1]),
            .rd_out     (rd_c[g+1]),
            .found_out  (found_c[g+1])
        );
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (apply)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (apply)
        begin
            rsp_value_reg  <= (ok && (req_func_reg == sil_pkg::FUNC_GET))
                              ? rd_c[CAPACITY] : '0;
            rsp_found_reg  <= (req_func_reg == sil_pkg::FUNC_CONTAINS) && found_c[CAPACITY];
            rsp_status_reg <= status;
            rsp_count_reg  <= count_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_value  = rsp_value_reg;
    assign rsp.found       = rsp_found_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.entry_count = rsp_count_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_accept_compare: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg == sil_pkg::S_COMPARE)
        else $error("accepted word not followed by compare");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_status_reg == sil_pkg::STAT_FULL) |-> rsp_count_reg == CAP_C)
        else $error("full status with room left");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> (count_reg == $past(count_reg) + COUNT_BITS'(1)))
        else $error("entry count moved by other than one");

endmodule

`default_nettype wire
